// ===== src/vfd_pkg.sv =====
// Package: transaction types and codes for the stop-bit varint field decoder.
`default_nettype none

package vfd_pkg;

    localparam logic [63:0] INT64_SIGN_BIT = 64'h8000_0000_0000_0000;
    localparam logic [63:0] UINT32_MAX     = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] INT32_NEG_MAX  = 64'h0000_0000_8000_0000;
    localparam logic [63:0] INT32_POS_MAX  = 64'h0000_0000_7FFF_FFFF;

    localparam logic [1:0] FMT_UINT64 = 2'd0;
    localparam logic [1:0] FMT_INT64  = 2'd1;
    localparam logic [1:0] FMT_UINT32 = 2'd2;
    localparam logic [1:0] FMT_INT32  = 2'd3;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_OVERFLOW = 2'd1;
    localparam logic [1:0] STAT_EOF      = 2'd2;

    localparam logic [3:0] COUNT_MAX = 4'hF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [1:0] command;
        logic       end_of_stream;
    } item_t;

    typedef struct packed {
        logic [63:0] value_bits;
        logic [1:0]  status;
        logic [3:0]  bytes_consumed;
    } result_t;

endpackage

`default_nettype wire

// ===== src/varint_field_decoder.sv =====
// Top level: big-endian stop-bit varint field decoder, one byte per transaction.
// A result appears in the cycle after the byte that ends or overflows a field.
// Throughput: one byte per cycle while ready; state and result update together.
// Input ready drops only while a result is held and the output is stalled.
// Reset (rst_n, async, active low) clears the field state and the result valid.
`default_nettype none

module varint_field_decoder
    import vfd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_valid,
    output logic         item_ready,
    input  wire item_t   item,
    output logic         result_valid,
    input  wire logic    result_ready,
    output result_t      result
);

    logic [63:0] acc_reg, acc_next;
    logic        neg_reg, neg_next;
    logic        in_field_reg, in_field_next;
    logic [1:0]  fmt_reg, fmt_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        out_valid_reg;
    result_t     out_reg;

    logic        accept;
    logic        emit;
    result_t     res;

    logic [63:0] mag;
    logic [63:0] neg_mag;
    logic [1:0]  fmt;
    logic        neg;
    logic [3:0]  cnt;
    logic        shift_ovf;
    logic        fin_ovf;
    logic [63:0] fin_val;

    assign item_ready   = !out_valid_reg || result_ready;
    assign accept       = item_valid && item_ready;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        if (in_field_reg)
        begin
            mag = {acc_reg[56:0], item.data_byte[6:0]};
            fmt = fmt_reg;
            neg = neg_reg;
            cnt = (cnt_reg == COUNT_MAX) ? COUNT_MAX : cnt_reg + 4'd1;
        end
        else
        begin
            mag = item.command[0] ? {58'd0, item.data_byte[5:0]}
                                  : {57'd0, item.data_byte[6:0]};
            fmt = item.command;
            neg = item.command[0] && item.data_byte[6];
            cnt = 4'd1;
        end
        shift_ovf = in_field_reg && (acc_reg[63:57] != 7'd0);
        neg_mag   = 64'd0 - mag;
    end

    always_comb
    begin
        fin_ovf = 1'b0;
        fin_val = mag;
        unique case (fmt)
            FMT_UINT64:
            begin
                fin_ovf = 1'b0;
                fin_val = mag;
            end
            FMT_UINT32:
            begin
                fin_ovf = mag > UINT32_MAX;
                fin_val = mag;
            end
            FMT_INT64:
            begin
                fin_ovf = neg ? (mag > INT64_SIGN_BIT) : (mag >= INT64_SIGN_BIT);
                fin_val = neg ? neg_mag : mag;
            end
            FMT_INT32:
            begin
                fin_ovf = neg ? (mag > INT32_NEG_MAX) : (mag > INT32_POS_MAX);
                fin_val = neg ? neg_mag : mag;
            end
            default:
            begin
                fin_ovf = 1'b0;
                fin_val = mag;
            end
        endcase
    end

    always_comb
    begin
        acc_next      = acc_reg;
        neg_next      = neg_reg;
        in_field_next = in_field_reg;
        fmt_next      = fmt_reg;
        cnt_next      = cnt_reg;
        emit          = 1'b0;
        res           = '{value_bits: 64'd0, status: STAT_OK, bytes_consumed: 4'd0};

        if (item.end_of_stream)
        begin
            emit          = 1'b1;
            res.status    = STAT_EOF;
            res.bytes_consumed = in_field_reg ? cnt_reg : 4'd0;
            acc_next      = 64'd0;
            neg_next      = 1'b0;
            cnt_next      = 4'd0;
            in_field_next = 1'b0;
        end
        else if (shift_ovf)
        begin
            emit          = 1'b1;
            res.status    = STAT_OVERFLOW;
            res.bytes_consumed = cnt;
            acc_next      = 64'd0;
            cnt_next      = 4'd0;
            in_field_next = 1'b0;
        end
        else
        begin
            fmt_next = fmt;
            neg_next = neg;
            if (item.data_byte[7])
            begin
                emit               = 1'b1;
                res.status         = fin_ovf ? STAT_OVERFLOW : STAT_OK;
                res.value_bits     = fin_ovf ? 64'd0 : fin_val;
                res.bytes_consumed = cnt;
                acc_next           = 64'd0;
                cnt_next           = 4'd0;
                in_field_next      = 1'b0;
            end
            else
            begin
                acc_next      = mag;
                cnt_next      = cnt;
                in_field_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= 64'd0;
            neg_reg       <= 1'b0;
            in_field_reg  <= 1'b0;
            fmt_reg       <= FMT_UINT64;
            cnt_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                acc_reg      <= acc_next;
                neg_reg      <= neg_next;
                in_field_reg <= in_field_next;
                fmt_reg      <= fmt_next;
                cnt_reg      <= cnt_next;
            end
            if (accept && emit)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
            out_reg <= res;
    end

`ifndef SYNTHESIS
    a_idle_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !in_field_reg |-> cnt_reg == 4'd0)
        else $error("byte count nonzero outside a field");

    a_field_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        in_field_reg |-> cnt_reg != 4'd0)
        else $error("field open with zero byte count");

    a_error_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status != STAT_OK |-> result.value_bits == 64'd0)
        else $error("nonzero value on error transaction");

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.status == STAT_OK || result.status == STAT_OVERFLOW
                         || result.status == STAT_EOF)
        else $error("illegal status code");

    a_ok_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == STAT_OK |-> result.bytes_consumed != 4'd0)
        else $error("ok transaction with no bytes");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/varint_field_decoder_tb.sv =====
// Self-checking testbench for the stop-bit varint field decoder.
`timescale 1ns / 1ps

import vfd_pkg::*;

class field_scoreboard;
    result_t     expected_fields[$];
    logic [63:0] magnitude;
    logic        negative;
    logic        in_field;
    logic [1:0]  format;
    logic [3:0]  count;
    int          mismatches;
    int          fields_checked;

    function new();
        magnitude      = '0;
        negative       = 1'b0;
        in_field       = 1'b0;
        format         = FMT_UINT64;
        count          = '0;
        mismatches     = 0;
        fields_checked = 0;
    endfunction

    function int pending();
        return expected_fields.size();
    endfunction

    function void push_field(logic [63:0] value, logic [1:0] code);
        result_t r;
        r.value_bits     = value;
        r.status         = code;
        r.bytes_consumed = count;
        expected_fields.push_back(r);
        in_field = 1'b0;
    endfunction

    function void finish_field();
        logic [63:0] twos;
        logic        too_big;
        twos = 64'd0 - magnitude;
        case (format)
            FMT_UINT64: push_field(magnitude, STAT_OK);
            FMT_UINT32:
            begin
                if (magnitude > UINT32_MAX)
                    push_field('0, STAT_OVERFLOW);
                else
                    push_field(magnitude, STAT_OK);
            end
            FMT_INT64:
            begin
                too_big = negative ? (magnitude > INT64_SIGN_BIT)
                                   : (magnitude >= INT64_SIGN_BIT);
                if (too_big)
                    push_field('0, STAT_OVERFLOW);
                else
                    push_field(negative ? twos : magnitude, STAT_OK);
            end
            default:
            begin
                too_big = negative ? (magnitude > INT32_NEG_MAX)
                                   : (magnitude > INT32_POS_MAX);
                if (too_big)
                    push_field('0, STAT_OVERFLOW);
                else
                    push_field(negative ? twos : magnitude, STAT_OK);
            end
        endcase
    endfunction

    // Predicts the result, if any, caused by one accepted transaction.
    function void note_byte(item_t it);
        if (it.end_of_stream) begin
            if (!in_field)
                count = '0;
            push_field('0, STAT_EOF);
            magnitude = '0;
            negative  = 1'b0;
            count     = '0;
            return;
        end
        if (!in_field) begin
            format = it.command;
            count  = 4'd1;
            if (it.command[0]) begin
                negative  = it.data_byte[6];
                magnitude = {58'd0, it.data_byte[5:0]};
            end
            else begin
                negative  = 1'b0;
                magnitude = {57'd0, it.data_byte[6:0]};
            end
            in_field = 1'b1;
        end
        else begin
            if (count != COUNT_MAX)
                count++;
            if (magnitude[63:57] != '0) begin
                push_field('0, STAT_OVERFLOW);
                magnitude = '0;
                count     = '0;
                return;
            end
            magnitude = {magnitude[56:0], it.data_byte[6:0]};
        end
        if (it.data_byte[7]) begin
            finish_field();
            magnitude = '0;
            count     = '0;
        end
    endfunction

    function void check_field(result_t got);
        result_t want;
        if (expected_fields.size() == 0) begin
            $error("unexpected result transaction: value_bits %h status %0d bytes_consumed %0d",
                   got.value_bits, got.status, got.bytes_consumed);
            mismatches++;
            return;
        end
        want = expected_fields.pop_front();
        fields_checked++;
        if (got.value_bits !== want.value_bits) begin
            $error("value_bits: expected %h, actual %h", want.value_bits, got.value_bits);
            mismatches++;
        end
        if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            mismatches++;
        end
        if (got.bytes_consumed !== want.bytes_consumed) begin
            $error("bytes_consumed: expected %0d, actual %0d",
                   want.bytes_consumed, got.bytes_consumed);
            mismatches++;
        end
    endfunction
endclass

module varint_field_decoder_tb;

    localparam int ITEM_TARGET = 1850;
    localparam int CALM_AFTER  = 1500;
    localparam int QUIET_LIMIT = 3000;

    logic    clk;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_ready;
    item_t   item         = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;

    field_scoreboard sb;
    int items_sent  = 0;
    bit calm        = 1'b0;
    bit source_gaps = 1'b1;

    varint_field_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic item_t make_item(logic [7:0] b, logic [1:0] cmd, logic eos);
        item_t it;
        it.data_byte     = b;
        it.command       = cmd;
        it.end_of_stream = eos;
        return it;
    endfunction

    // Builds the byte sequence of one field, optionally with leading zero groups
    // and optionally cut short by an end of stream instead of a stop bit.
    function automatic void encode_field(input logic [1:0] fmt, input logic neg,
                                         input logic [63:0] mag, input int pad,
                                         input bit terminate, ref item_t seq[$]);
        logic [7:0]  bytes[$];
        logic [63:0] rest;
        logic [7:0]  lead;
        rest = mag;
        while (rest > (fmt[0] ? 64'd63 : 64'd127)) begin
            bytes.push_front({1'b0, rest[6:0]});
            rest = rest >> 7;
        end
        if (pad > 0) begin
            bytes.push_front({1'b0, rest[6:0]});
            repeat (pad - 1) bytes.push_front(8'h00);
            rest = '0;
        end
        lead = {1'b0, rest[6:0]};
        if (fmt[0])
            lead[6] = neg;
        bytes.push_front(lead);
        if (terminate)
            bytes[bytes.size() - 1][7] = 1'b1;
        foreach (bytes[i])
            seq.push_back(make_item(bytes[i], (i == 0) ? fmt : 2'($urandom_range(0, 3)), 1'b0));
        if (!terminate)
            seq.push_back(make_item(8'($urandom), 2'($urandom_range(0, 3)), 1'b1));
    endfunction

    task automatic send_byte(input item_t it);
        if (!calm && source_gaps && $urandom_range(0, 5) == 0) begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        sb.note_byte(it);
        items_sent++;
    endtask

    task automatic send_field(input item_t seq[$]);
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    task automatic random_field();
        item_t       seq[$];
        logic [63:0] limits[14];
        logic [63:0] mag;
        logic [1:0]  fmt;
        logic [7:0]  b;
        int          pick;
        int          w;
        int          n;
        int          pad;
        limits = '{64'd0, 64'h3F, 64'h40, 64'h7F, 64'h80, INT32_POS_MAX, INT32_NEG_MAX,
                   INT32_NEG_MAX + 1, UINT32_MAX, UINT32_MAX + 1, INT64_SIGN_BIT - 1,
                   INT64_SIGN_BIT, INT64_SIGN_BIT + 1, 64'hFFFF_FFFF_FFFF_FFFF};
        if ($urandom_range(0, 5) == 0)
            source_gaps = !source_gaps;
        fmt  = 2'($urandom_range(0, 3));
        pick = $urandom_range(0, 99);
        pad  = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
        if (pick < 45) begin
            w   = $urandom_range(0, 64);
            mag = {$urandom, $urandom};
            if (w < 64)
                mag = mag & ((64'd1 << w) - 64'd1);
            encode_field(fmt, 1'($urandom), mag, pad, $urandom_range(0, 14) != 0, seq);
        end
        else if (pick < 65) begin
            mag = limits[$urandom_range(0, 13)];
            case ($urandom_range(0, 3))
                0: mag = mag - 64'd1;
                1: mag = mag + 64'd1;
                default: ;
            endcase
            encode_field(fmt, 1'($urandom), mag, pad, 1'b1, seq);
        end
        else if (pick < 80) begin
            // many significant groups: overflow while gathering, or bit 63 set for ten groups
            n = $urandom_range(10, 13);
            for (int i = 0; i < n; i++) begin
                b    = 8'($urandom);
                b[7] = (i == n - 1);
                if (i == 0)
                    b[0] = 1'b1;
                seq.push_back(make_item(b, (i == 0) ? fmt : 2'($urandom_range(0, 3)), 1'b0));
            end
        end
        else if (pick < 92) begin
            n = $urandom_range(1, 6);
            repeat (n)
                seq.push_back(make_item(8'($urandom), 2'($urandom_range(0, 3)),
                                        $urandom_range(0, 7) == 0));
        end
        else if (pick < 96) begin
            seq.push_back(make_item(8'($urandom), 2'($urandom_range(0, 3)), 1'b1));
        end
        else begin
            // long zero padding drives the byte count into saturation
            encode_field(fmt, 1'($urandom), 64'($urandom_range(0, 200)),
                         $urandom_range(14, 20), 1'b1, seq);
        end
        send_field(seq);
        if (items_sent >= CALM_AFTER)
            calm = 1'b1;
    endtask

    initial begin : stimulus
        item_t seq[$];
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_byte(make_item(8'h5A, FMT_UINT64, 1'b1));
        encode_field(FMT_UINT64, 1'b0, 64'd0, 0, 1'b1, seq);
        encode_field(FMT_UINT64, 1'b0, 64'h7F, 0, 1'b1, seq);
        encode_field(FMT_INT64, 1'b1, 64'd0, 0, 1'b1, seq);
        encode_field(FMT_INT32, 1'b1, INT32_NEG_MAX, 0, 1'b1, seq);
        encode_field(FMT_INT32, 1'b0, INT32_NEG_MAX, 0, 1'b1, seq);
        encode_field(FMT_UINT32, 1'b0, UINT32_MAX + 1, 0, 1'b1, seq);
        encode_field(FMT_INT32, 1'b0, 64'h3F, 0, 1'b1, seq);
        encode_field(FMT_INT64, 1'b1, 64'd1, 0, 1'b0, seq);
        send_field(seq);

        while (items_sent < ITEM_TARGET)
            random_field();
        item_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("varint_field_decoder regression: pass");
        else
            $display("varint_field_decoder regression: fail");
        $finish;
    end

    initial begin : result_sink
        int hold;
        bit pressured;
        bit sink_stalls;
        hold        = 0;
        pressured   = 1'b0;
        sink_stalls = 1'b1;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (result_valid && result_ready)
                sb.check_field(result);
            if ($urandom_range(0, 149) == 0)
                sink_stalls = !sink_stalls;
            if (hold > 0)
                hold--;
            else if (!pressured && sb.fields_checked >= 300) begin
                // long hold-off so the decoder backs up into its input
                pressured = 1'b1;
                hold      = 250;
            end
            else if (!calm && sink_stalls && $urandom_range(0, 9) == 0)
                hold = $urandom_range(1, 14);
            result_ready <= (hold == 0);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((item_valid && item_ready) || (result_valid && result_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("varint_field_decoder regression: fail");
        $finish;
    end

endmodule
